### rtl/congestion_window_controller_top_defines.svh
// Assertion macros for the congestion window controller.
// Used by the top level; no other dependencies.
`ifndef CONGESTION_WINDOW_CONTROLLER_TOP_DEFINES_SVH
`define CONGESTION_WINDOW_CONTROLLER_TOP_DEFINES_SVH

`ifndef SYNTHESIS
// checked only out of reset
`define CWC_ASSERT(label, prop) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error("cwc assertion failed");
// checked on every edge, reset included
`define CWC_ASSERT_ALWAYS(label, prop) \
  label: assert property (@(posedge clk) (prop)) \
    else $error("cwc assertion failed");
`else
`define CWC_ASSERT(label, prop)
`define CWC_ASSERT_ALWAYS(label, prop)
`endif

`endif

### rtl/cwc_pkg.sv
// Shared types and codes for the congestion window controller.
// No dependencies.
`default_nettype none
package cwc_pkg;

  localparam int unsigned WinW  = 16;
  localparam int unsigned CfgIdxW = 3;

  typedef logic [WinW-1:0] win_t;

  // opcodes
  localparam logic [1:0] OP_TICK    = 2'd0;
  localparam logic [1:0] OP_REPORT  = 2'd1;
  localparam logic [1:0] OP_RESTART = 2'd2;

  // report status
  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_OVERLOAD = 2'd1;
  localparam logic [1:0] ST_HEAVY    = 2'd2;

  // configuration register indexes
  localparam logic [CfgIdxW-1:0] CFG_INITIAL_WINDOW    = 3'd0;
  localparam logic [CfgIdxW-1:0] CFG_MAX_WINDOW        = 3'd1;
  localparam logic [CfgIdxW-1:0] CFG_SEGMENT_SIZE      = 3'd2;
  localparam logic [CfgIdxW-1:0] CFG_INITIAL_THRESHOLD = 3'd3;
  localparam logic [CfgIdxW-1:0] CFG_WINDOW_PERIOD     = 3'd4;

  // configuration as seen by the update logic (zero windows already mapped to one)
  typedef struct packed {
    win_t eff_init;
    win_t eff_max;
    win_t segment;
    win_t init_thr;
    win_t period;
  } cwc_cfg_t;

  typedef struct packed {
    win_t win;
    win_t thr;
    win_t ticks;
  } cwc_state_t;

endpackage
`default_nettype wire

### rtl/cwc_cfg_regs.sv
// Configuration register file with effective-value decode.
// Depends on cwc_pkg.
`default_nettype none
module cwc_cfg_regs
  import cwc_pkg::*;
(
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               cfg_we,
  input  wire logic [CfgIdxW-1:0] cfg_index,
  input  wire logic [WinW-1:0]    cfg_wdata,
  output cwc_cfg_t                cfg
);

  win_t init_win_r, max_win_r, segment_r, init_thr_r, period_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      init_win_r <= win_t'(1);
      max_win_r  <= '1;
      segment_r  <= win_t'(1);
      init_thr_r <= '0;
      period_r   <= win_t'(16);
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_INITIAL_WINDOW:    init_win_r <= cfg_wdata;
        CFG_MAX_WINDOW:        max_win_r  <= cfg_wdata;
        CFG_SEGMENT_SIZE:      segment_r  <= cfg_wdata;
        CFG_INITIAL_THRESHOLD: init_thr_r <= cfg_wdata;
        CFG_WINDOW_PERIOD:     period_r   <= cfg_wdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    cfg.eff_init = (init_win_r == '0) ? win_t'(1) : init_win_r;
    cfg.eff_max  = (max_win_r == '0) ? win_t'(1) : max_win_r;
    cfg.segment  = segment_r;
    cfg.init_thr = init_thr_r;
    cfg.period   = period_r;
  end

endmodule
`default_nettype wire

### rtl/cwc_update.sv
// Next-state logic: window, threshold and period count for one word.
// Depends on cwc_pkg.
`default_nettype none
module cwc_update
  import cwc_pkg::*;
(
  input  wire logic [1:0] opcode,
  input  wire logic [1:0] report_status,
  input  cwc_state_t      cur,
  input  cwc_cfg_t        cfg,
  output cwc_state_t      nxt,
  output logic [1:0]      applied
);

  logic          full;
  logic [1:0]    st_eff;
  logic [WinW:0] grow_add, grow_dbl, thr_w, cand;
  win_t          half, rep_thr, rep_win;

  always_comb begin
    full     = (cur.ticks >= cfg.period);
    half     = cur.win >> 1;
    grow_add = {1'b0, cur.win} + {1'b0, cfg.segment};
    grow_dbl = {cur.win, 1'b0};
    thr_w    = {1'b0, cur.thr};

    st_eff = (report_status == 2'd3) ? ST_HEAVY : report_status;
    // sitting at the max for a full period forces overload
    if ((cur.win == cfg.eff_max) && full) st_eff = ST_OVERLOAD;

    rep_thr = cur.thr;
    case (st_eff)
      ST_OK: begin
        if (!full) cand = {1'b0, cur.win};
        else if (cur.win >= cur.thr) cand = grow_add;
        else cand = (grow_dbl > thr_w) ? thr_w : grow_dbl;
      end
      ST_OVERLOAD: begin
        rep_thr = half;
        cand    = {1'b0, half};
      end
      default: begin
        rep_thr = half;
        cand    = {1'b0, cfg.eff_init};
      end
    endcase

    // clamp; the initial window wins over the max
    if (cand > {1'b0, cfg.eff_max}) cand = {1'b0, cfg.eff_max};
    if (cand < {1'b0, cfg.eff_init}) cand = {1'b0, cfg.eff_init};
    rep_win = cand[WinW-1:0];

    nxt     = cur;
    applied = ST_OK;
    case (opcode)
      OP_TICK: begin
        if (cur.ticks != '1) nxt.ticks = cur.ticks + win_t'(1);
      end
      OP_REPORT: begin
        applied = st_eff;
        nxt.win = rep_win;
        nxt.thr = rep_thr;
        if (rep_win != cur.win) nxt.ticks = '0;
      end
      OP_RESTART: begin
        nxt.win   = cfg.eff_init;
        nxt.thr   = ((cfg.init_thr != '0) && (cfg.init_thr < cfg.eff_max)) ?
                    cfg.init_thr : cfg.eff_max;
        nxt.ticks = '0;
      end
      default: ;
    endcase
  end

endmodule
`default_nettype wire

### rtl/congestion_window_controller_top.sv
// Path: a word taken into the input register is updated and its result loaded into the result register.
// Throughput: one word per cycle unless a stalled result holds it; the single update
// stage between the input and result registers closes the state loop.
// Input and result registers decouple the two channels, so a stalled result
// does not stop the next word from being taken into an empty input register.
// Reset (synchronous, rst_n low): window 1, threshold 65535, period count 0,
// configuration to its defaults, both channels empty.
`default_nettype none
`include "congestion_window_controller_top_defines.svh"
module congestion_window_controller_top
  import cwc_pkg::*;
(
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               cfg_we,
  input  wire logic [CfgIdxW-1:0] cfg_index,
  input  wire logic [WinW-1:0]    cfg_wdata,
  input  wire logic               in_valid,
  output logic                    in_ready,
  input  wire logic [1:0]         in_opcode,
  input  wire logic [1:0]         in_report_status,
  output logic                    out_valid,
  input  wire logic               out_ready,
  output logic [WinW-1:0]         out_window,
  output logic [WinW-1:0]         out_threshold,
  output logic [1:0]              out_applied_status,
  output logic                    out_congested,
  output logic [WinW-1:0]         out_previous_window
);

  cwc_cfg_t   cfg;
  cwc_state_t state_r, state_nxt;
  logic [1:0] applied;

  logic       in_valid_r;
  logic [1:0] opcode_r, status_r;
  logic       out_valid_r;
  win_t       out_win_r, out_thr_r, out_prev_r;
  logic [1:0] out_applied_r;
  logic       advance, fire;

  cwc_cfg_regs u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg)
  );

  cwc_update u_update (
    .opcode        (opcode_r),
    .report_status (status_r),
    .cur           (state_r),
    .cfg           (cfg),
    .nxt           (state_nxt),
    .applied       (applied)
  );

  assign advance  = !out_valid_r || out_ready;
  assign fire     = in_valid_r && advance;
  assign in_ready = !in_valid_r || advance;

  // input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_ready) begin
      in_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      opcode_r <= in_opcode;
      status_r <= in_report_status;
    end
  end

  // controller state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r.win   <= win_t'(1);
      state_r.thr   <= '1;
      state_r.ticks <= '0;
    end else if (fire) begin
      state_r <= state_nxt;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= in_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      out_win_r     <= state_nxt.win;
      out_thr_r     <= state_nxt.thr;
      out_applied_r <= applied;
      out_prev_r    <= state_r.win;
    end
  end

  assign out_valid           = out_valid_r;
  assign out_window          = out_win_r;
  assign out_threshold       = out_thr_r;
  assign out_applied_status  = out_applied_r;
  assign out_congested       = (out_applied_r != ST_OK);
  assign out_previous_window = out_prev_r;

  `CWC_ASSERT(a_win_nonzero, state_r.win != '0)
  `CWC_ASSERT(a_room_means_ready, !out_valid_r |-> in_ready)
  `CWC_ASSERT(a_change_clears_ticks, (fire && (state_nxt.win != state_r.win)) |=> (state_r.ticks == '0))
  `CWC_ASSERT(a_restart_thr_bound, (fire && (opcode_r == OP_RESTART)) |=> (state_r.thr <= cfg.eff_max))
  `CWC_ASSERT_ALWAYS(a_reset_empties, !rst_n |=> (!out_valid_r && !in_valid_r))

endmodule
`default_nettype wire

### tb/tb_congestion_window_controller_top.sv
// Self-checking testbench for congestion_window_controller_top: a directed table
// and randomized phases with sender and receiver idling. Depends on cwc_pkg and the top level;
// results are checked against an in-bench window model, or the table's known values.
`timescale 1ns / 100ps
module tb_congestion_window_controller_top;
  import cwc_pkg::*;

  localparam logic [1:0] OP_UNUSED = 2'd3;
  localparam logic [1:0] ST_UNUSED = 2'd3;
  localparam int unsigned CYCLE_LIMIT = 1000000;
  localparam int unsigned EXP_DEPTH = 16;
  localparam int unsigned ROW_DEPTH = 64;

  typedef struct packed {
    win_t       window;
    win_t       threshold;
    logic [1:0] applied;
    logic       congested;
    win_t       prev_window;
  } cwnd_result_t;

  typedef enum logic {ROW_WORD, ROW_CFG} row_kind_t;

  typedef struct packed {
    row_kind_t           kind;
    logic [CfgIdxW-1:0]  reg_idx;
    win_t                reg_val;
    logic [1:0]          op;
    logic [1:0]          st;
    logic                known;
    cwnd_result_t        res;
  } stim_row_t;

  logic               clk = 1'b0;
  logic               rst_n;
  logic               cfg_we;
  logic [CfgIdxW-1:0] cfg_index;
  logic [WinW-1:0]    cfg_wdata;
  logic               in_valid;
  logic               in_ready;
  logic [1:0]         in_opcode;
  logic [1:0]         in_report_status;
  logic               out_valid;
  logic               out_ready = 1'b0;
  logic [WinW-1:0]    out_window;
  logic [WinW-1:0]    out_threshold;
  logic [1:0]         out_applied_status;
  logic               out_congested;
  logic [WinW-1:0]    out_previous_window;

  // window model: configuration and state
  win_t cfg_init_win = 16'd1;
  win_t cfg_max_win  = 16'hFFFF;
  win_t cfg_seg      = 16'd1;
  win_t cfg_init_thr = 16'd0;
  win_t cfg_period   = 16'd16;
  win_t win_now      = 16'd1;
  win_t thr_now      = 16'hFFFF;
  win_t ticks_now    = 16'd0;

  // expected results in flight, oldest at the read pointer
  cwnd_result_t exp_fifo[EXP_DEPTH];
  logic [3:0]   exp_wr_ptr = 4'd0;
  logic [3:0]   exp_rd_ptr = 4'd0;
  int unsigned  exp_count = 0;

  stim_row_t    rows[ROW_DEPTH];
  int unsigned  n_rows = 0;

  int unsigned  mismatches = 0;
  int unsigned  cycle_count = 0;
  int unsigned  idle_pct = 0;
  int unsigned  stall_pct = 0;

  congestion_window_controller_top i_dut (
    .clk                 (clk),
    .rst_n               (rst_n),
    .cfg_we              (cfg_we),
    .cfg_index           (cfg_index),
    .cfg_wdata           (cfg_wdata),
    .in_valid            (in_valid),
    .in_ready            (in_ready),
    .in_opcode           (in_opcode),
    .in_report_status    (in_report_status),
    .out_valid           (out_valid),
    .out_ready           (out_ready),
    .out_window          (out_window),
    .out_threshold       (out_threshold),
    .out_applied_status  (out_applied_status),
    .out_congested       (out_congested),
    .out_previous_window (out_previous_window)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // advance the window model by one word and return what the block should report
  function automatic cwnd_result_t advance_cwnd(input logic [1:0] op, input logic [1:0] st);
    cwnd_result_t r;
    logic [16:0]  grown;
    win_t         lo;
    win_t         hi;
    logic         full;
    logic [1:0]   app;
    lo = (cfg_init_win == 16'd0) ? 16'd1 : cfg_init_win;
    hi = (cfg_max_win == 16'd0) ? 16'd1 : cfg_max_win;
    app = ST_OK;
    r.prev_window = win_now;
    case (op)
      OP_TICK: begin
        if (ticks_now != 16'hFFFF) ticks_now = ticks_now + 16'd1;
      end
      OP_RESTART: begin
        win_now = lo;
        thr_now = (cfg_init_thr != 16'd0 && cfg_init_thr < hi) ? cfg_init_thr : hi;
        ticks_now = 16'd0;
      end
      OP_REPORT: begin
        full = (ticks_now >= cfg_period);
        app = (st == ST_UNUSED) ? ST_HEAVY : st;
        // a window parked at the max for a full period is treated as overloaded
        if (win_now == hi && full) app = ST_OVERLOAD;
        grown = {1'b0, win_now};
        case (app)
          ST_OK: begin
            if (full) begin
              if (win_now >= thr_now) begin
                grown = {1'b0, win_now} + {1'b0, cfg_seg};
              end else begin
                grown = {win_now, 1'b0};
                if (grown > {1'b0, thr_now}) grown = {1'b0, thr_now};
              end
            end
          end
          ST_OVERLOAD: begin
            thr_now = win_now >> 1;
            grown = {1'b0, thr_now};
          end
          default: begin
            thr_now = win_now >> 1;
            grown = {1'b0, lo};
          end
        endcase
        if (grown > {1'b0, hi}) grown = {1'b0, hi};
        if (grown < {1'b0, lo}) grown = {1'b0, lo};
        if (grown[15:0] != win_now) ticks_now = 16'd0;
        win_now = grown[15:0];
      end
      default: ;
    endcase
    r.window = win_now;
    r.threshold = thr_now;
    r.applied = app;
    r.congested = (app != ST_OK);
    return r;
  endfunction

  function automatic stim_row_t word_row(input logic [1:0] op, input logic [1:0] st);
    stim_row_t row;
    row = '0;
    row.kind = ROW_WORD;
    row.op = op;
    row.st = st;
    return row;
  endfunction

  function automatic stim_row_t known_row(input logic [1:0] op, input logic [1:0] st,
                                          input win_t win, input win_t thr,
                                          input logic [1:0] app, input logic cong,
                                          input win_t prev);
    stim_row_t row;
    row = word_row(op, st);
    row.known = 1'b1;
    row.res.window = win;
    row.res.threshold = thr;
    row.res.applied = app;
    row.res.congested = cong;
    row.res.prev_window = prev;
    return row;
  endfunction

  function automatic stim_row_t reg_row(input logic [CfgIdxW-1:0] idx, input win_t val);
    stim_row_t row;
    row = '0;
    row.kind = ROW_CFG;
    row.reg_idx = idx;
    row.reg_val = val;
    return row;
  endfunction

  function automatic void add_row(input stim_row_t row);
    rows[n_rows] = row;
    n_rows++;
  endfunction

  function automatic win_t pick_val(input int unsigned typ_hi);
    case ($urandom_range(9))
      0:       return 16'd0;
      1:       return 16'd1;
      2:       return 16'hFFFF;
      3:       return win_t'($urandom_range(65535));
      default: return win_t'($urandom_range(typ_hi, 1));
    endcase
  endfunction

  function automatic void check_field(input string name, input win_t want, input win_t got);
    if (want != got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      mismatches++;
    end
  endfunction

  // one register write; we drops in the following cycle
  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input win_t val);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      CFG_INITIAL_WINDOW:    cfg_init_win = val;
      CFG_MAX_WINDOW:        cfg_max_win = val;
      CFG_SEGMENT_SIZE:      cfg_seg = val;
      CFG_INITIAL_THRESHOLD: cfg_init_thr = val;
      CFG_WINDOW_PERIOD:     cfg_period = val;
      default: ;
    endcase
    @(posedge clk);
  endtask

  task automatic send_word(input logic [1:0] op, input logic [1:0] st, input logic known,
                           input cwnd_result_t known_res);
    cwnd_result_t pred;
    while ($urandom_range(99) < idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_opcode <= op;
    in_report_status <= st;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    pred = advance_cwnd(op, st);
    exp_fifo[exp_wr_ptr] = known ? known_res : pred;
    exp_wr_ptr = exp_wr_ptr + 4'd1;
    exp_count++;
  endtask

  // drop in_valid, wait for every pending result, then idle before returning
  task automatic settle();
    in_valid <= 1'b0;
    while (exp_count != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic random_config();
    write_reg(CFG_INITIAL_WINDOW, pick_val(8));
    write_reg(CFG_MAX_WINDOW, pick_val(5000));
    write_reg(CFG_SEGMENT_SIZE, pick_val(64));
    write_reg(CFG_INITIAL_THRESHOLD, pick_val(200));
    write_reg(CFG_WINDOW_PERIOD, pick_val(4));
  endtask

  always @(posedge clk) begin
    out_ready <= ($urandom_range(99) >= stall_pct);
  end

  always @(posedge clk) begin : result_check
    cwnd_result_t want;
    if (rst_n && out_valid && out_ready) begin
      if (exp_count == 0) begin
        $error("result word with no expectation pending");
        mismatches++;
      end else begin
        want = exp_fifo[exp_rd_ptr];
        exp_rd_ptr = exp_rd_ptr + 4'd1;
        exp_count--;
        check_field("window", want.window, out_window);
        check_field("threshold", want.threshold, out_threshold);
        check_field("applied_status", win_t'(want.applied), win_t'(out_applied_status));
        check_field("congested", win_t'(want.congested), win_t'(out_congested));
        check_field("previous_window", want.prev_window, out_previous_window);
      end
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  initial begin
    logic        dirty;
    int unsigned pick;
    logic [1:0]  op;
    logic [1:0]  st;
    rst_n = 1'b0;
    cfg_we = 1'b0;
    cfg_index = '0;
    cfg_wdata = '0;
    in_valid = 1'b0;
    in_opcode = OP_TICK;
    in_report_status = ST_OK;
    dirty = 1'b0;

    // defaults: report before a full period holds, status three acts as heavy
    add_row(known_row(OP_TICK, ST_OK, 16'd1, 16'hFFFF, ST_OK, 1'b0, 16'd1));
    add_row(known_row(OP_REPORT, ST_OK, 16'd1, 16'hFFFF, ST_OK, 1'b0, 16'd1));
    add_row(known_row(OP_REPORT, ST_UNUSED, 16'd1, 16'd0, ST_HEAVY, 1'b1, 16'd1));
    add_row(known_row(OP_UNUSED, ST_HEAVY, 16'd1, 16'd0, ST_OK, 1'b0, 16'd1));
    add_row(known_row(OP_RESTART, ST_OVERLOAD, 16'd1, 16'hFFFF, ST_OK, 1'b0, 16'd1));
    // zero period: slow start, overload, additive step, a wide sum clamped, then overload forced at the max
    add_row(reg_row(CFG_WINDOW_PERIOD, 16'd0));
    add_row(word_row(OP_REPORT, ST_OK));
    add_row(word_row(OP_REPORT, ST_OK));
    add_row(word_row(OP_REPORT, ST_OK));
    add_row(word_row(OP_REPORT, ST_OVERLOAD));
    add_row(word_row(OP_REPORT, ST_OK));
    add_row(reg_row(CFG_SEGMENT_SIZE, 16'hFFFF));
    add_row(word_row(OP_REPORT, ST_OK));
    add_row(known_row(OP_REPORT, ST_OK, 16'd32767, 16'd32767, ST_OVERLOAD, 1'b1,
                      16'hFFFF));
    // zero init and zero max both act as one
    add_row(reg_row(CFG_MAX_WINDOW, 16'd0));
    add_row(reg_row(CFG_INITIAL_WINDOW, 16'd0));
    add_row(known_row(OP_RESTART, ST_OK, 16'd1, 16'd1, ST_OK, 1'b0, 16'd32767));
    add_row(known_row(OP_REPORT, ST_OK, 16'd1, 16'd0, ST_OVERLOAD, 1'b1, 16'd1));
    // init above max wins
    add_row(reg_row(CFG_INITIAL_WINDOW, 16'hFFFF));
    add_row(reg_row(CFG_MAX_WINDOW, 16'd100));
    add_row(known_row(OP_RESTART, ST_OK, 16'hFFFF, 16'd100, ST_OK, 1'b0, 16'd1));
    add_row(word_row(OP_REPORT, ST_HEAVY));
    // nonzero initial threshold and a short period
    add_row(reg_row(CFG_INITIAL_WINDOW, 16'd4));
    add_row(reg_row(CFG_MAX_WINDOW, 16'd1000));
    add_row(reg_row(CFG_INITIAL_THRESHOLD, 16'd50));
    add_row(reg_row(CFG_WINDOW_PERIOD, 16'd3));
    add_row(reg_row(CFG_SEGMENT_SIZE, 16'd10));
    add_row(known_row(OP_RESTART, ST_OK, 16'd4, 16'd50, ST_OK, 1'b0, 16'hFFFF));
    add_row(word_row(OP_REPORT, ST_OK));
    repeat (3) add_row(word_row(OP_TICK, ST_UNUSED));
    add_row(word_row(OP_REPORT, ST_OK));
    add_row(word_row(OP_REPORT, ST_OK));
    repeat (3) add_row(word_row(OP_TICK, ST_OK));
    add_row(word_row(OP_REPORT, ST_HEAVY));
    // threshold register above max falls back to max
    add_row(reg_row(CFG_INITIAL_THRESHOLD, 16'hFFFF));
    add_row(known_row(OP_RESTART, ST_OK, 16'd4, 16'd1000, ST_OK, 1'b0, 16'd4));

    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    for (int i = 0; i < n_rows; i++) begin
      if (rows[i].kind == ROW_CFG) begin
        if (dirty) settle();
        dirty = 1'b0;
        write_reg(rows[i].reg_idx, rows[i].reg_val);
      end else begin
        send_word(rows[i].op, rows[i].st, rows[i].known, rows[i].res);
        dirty = 1'b1;
      end
    end

    for (int ph = 0; ph < 8; ph++) begin
      settle();
      case (ph % 4)
        0: begin idle_pct = 0;  stall_pct = 0;  end
        1: begin idle_pct = 78; stall_pct = 0;  end
        2: begin idle_pct = 0;  stall_pct = 78; end
        default: begin idle_pct = 13; stall_pct = 13; end
      endcase
      random_config();
      send_word(OP_RESTART, 2'($urandom_range(3)), 1'b0, '0);
      repeat (149) begin
        pick = $urandom_range(99);
        if (pick < 45)      op = OP_TICK;
        else if (pick < 88) op = OP_REPORT;
        else if (pick < 95) op = OP_RESTART;
        else                op = OP_UNUSED;
        pick = $urandom_range(99);
        if (pick < 55)      st = ST_OK;
        else if (pick < 75) st = ST_OVERLOAD;
        else if (pick < 88) st = ST_HEAVY;
        else                st = ST_UNUSED;
        send_word(op, st, 1'b0, '0);
      end
    end

    settle();
    if (mismatches == 0 && exp_count == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
